// File: src/sft_pkg.sv
`default_nettype none
package sft_pkg;
	localparam int unsigned TableEntries = 256;
	localparam int unsigned MaxReportRows = 64;
	localparam int unsigned IdxW = $clog2(TableEntries);
	localparam int unsigned UsedW = $clog2(TableEntries + 1);
	localparam logic [6:0] TopCountReset = 7'd10;
	localparam logic OpRecord = 1'b0;
	localparam logic OpReport = 1'b1;

	typedef struct packed {
		logic [23:0] key;
		logic [63:0] reg_low;
		logic [7:0]  reg_high;
		logic [31:0] count;
	} entry_t;

	typedef struct packed {
		logic        opcode;
		logic [23:0] address_key;
		logic [63:0] reg_low_bytes;
		logic [7:0]  reg_high_byte;
		logic        reg_present;
	} in_item_t;

	typedef struct packed {
		logic        row_valid;
		logic [5:0]  rank;
		logic [23:0] ranked_key;
		logic [63:0] ranked_reg_low;
		logic [7:0]  ranked_reg_high;
		logic [31:0] sighting_total;
		logic        last_row;
	} out_item_t;

	// one request travels down the chain of cells
	typedef struct packed {
		logic   match;    // find matching key / best count
		logic   sel;      // selection pass
		logic   found;
		logic [IdxW-1:0] pos;
		entry_t ent;
	} probe_t;
endpackage
`default_nettype wire

// File: src/sft_cell.sv
`default_nettype none
// one table slot; probe runs through, compares, and hands on
module sft_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [sft_pkg::IdxW-1:0] my_idx,
	input  wire logic active,
	input  wire sft_pkg::probe_t p_in,
	output sft_pkg::probe_t p_out,
	input  wire logic wr_en,
	input  wire sft_pkg::entry_t wr_data,
	output sft_pkg::entry_t ent
);
	sft_pkg::entry_t ent_q;
	sft_pkg::probe_t p_q;
	sft_pkg::probe_t p_d;
	logic hit;
	logic better;

	assign ent = ent_q;
	assign hit = p_in.match && active && !p_in.found && (ent_q.key == p_in.ent.key);
	assign better = p_in.sel && active && (ent_q.count > p_in.ent.count);

	always_comb begin
		p_d = p_in;
		if (hit) begin
			p_d.found = 1'b1;
			p_d.pos = my_idx;
			p_d.ent = ent_q;
		end
		if (better) begin
			p_d.pos = my_idx;
			p_d.ent = ent_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else begin
			p_q <= p_d;
		end
	end
	assign p_out = p_q;
endmodule
`default_nettype wire

// File: src/sighting_frequency_top_k_core.sv
`default_nettype none
// sighting frequency counter with ranked report
// in channel: in_valid/in_ready with in_data (opcode, address, registration)
// out channel: out_valid/out_ready with out_data, one transfer per ranked row
// cfg: cfg_we/cfg_wdata writes top_count (reset 10, above 64 acts as 64)
// a record runs one probe down the 256-cell chain; no result is produced
// a report runs one selection pass down the chain per row, swaps the
// winner into place and issues the row; then clears
// with no rows, one invalid row with last_row set is sent
// the row register holds while out_ready is low; the next pass waits
// reset empties the table and returns to idle; no clearing pass needed
module sighting_frequency_top_k_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire sft_pkg::in_item_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output sft_pkg::out_item_t out_data,
	input  wire logic cfg_we,
	input  wire logic [6:0] cfg_wdata
);
	localparam int unsigned N = sft_pkg::TableEntries;
	localparam int unsigned IW = sft_pkg::IdxW;
	localparam int unsigned UW = sft_pkg::UsedW;
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StRun = 3'd1;
	localparam logic [2:0] StRec = 3'd2;
	localparam logic [2:0] StPick = 3'd3;
	localparam logic [2:0] StEmit = 3'd4;
	localparam sft_pkg::out_item_t EmptyRow = '{default: '0, last_row: 1'b1};

	logic [2:0] state_q;
	logic [6:0] top_q;
	logic [UW-1:0] used_q;
	logic [6:0] rows_q;
	logic [6:0] r_q;
	logic [UW-1:0] cnt_q;
	sft_pkg::in_item_t item_q;
	sft_pkg::out_item_t out_q;
	logic out_v_q;
	logic is_sel_q;

	sft_pkg::probe_t chain [0:N];
	sft_pkg::entry_t ents [0:N-1];
	logic [N-1:0] wr_en;
	sft_pkg::entry_t wr_data [0:N-1];
	sft_pkg::probe_t inject;

	logic [6:0] limit;
	logic [UW-1:0] used_rows;
	logic [6:0] rows_c;
	sft_pkg::probe_t res;
	logic [IW-1:0] r_idx;
	logic [IW-1:0] u_idx;
	sft_pkg::entry_t new_ent;
	logic [31:0] cnt_inc;
	logic run_hold;

	assign limit = (top_q > 7'(sft_pkg::MaxReportRows)) ? 7'(sft_pkg::MaxReportRows) : top_q;
	assign used_rows = (used_q < UW'(limit)) ? used_q : UW'(limit);
	assign rows_c = 7'(used_rows);
	assign res = chain[N];
	assign r_idx = IW'(r_q);
	assign u_idx = used_q[IW-1:0];
	assign chain[0] = inject;
	assign run_hold = (cnt_q == '0) && out_v_q;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			sft_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.my_idx(IW'(g)),
				.active((UW'(g) < used_q) && (!is_sel_q || (7'(g) > r_q) || (g > 127))),
				.p_in(chain[g]), .p_out(chain[g+1]),
				.wr_en(wr_en[g]), .wr_data(wr_data[g]), .ent(ents[g])
			);
		end
	endgenerate

	always_comb begin
		cnt_inc = (res.ent.count == 32'hFFFF_FFFF) ? res.ent.count : res.ent.count + 32'd1;
		new_ent = res.ent;
		new_ent.count = cnt_inc;
		if (!res.found) begin
			new_ent.reg_low = '0;
			new_ent.reg_high = '0;
			new_ent.count = 32'd1;
		end
		if (item_q.reg_present) begin
			new_ent.reg_low = item_q.reg_low_bytes;
			new_ent.reg_high = item_q.reg_high_byte;
		end
		wr_en = '0;
		for (int i = 0; i < N; i++) begin
			wr_data[i] = new_ent;
		end
		if (state_q == StRec) begin
			if (res.found) begin
				wr_en[res.pos] = 1'b1;
			end else if (used_q < UW'(N)) begin
				wr_en[u_idx] = 1'b1;
			end
		end
		if (state_q == StPick && res.pos != r_idx) begin
			wr_en[r_idx] = 1'b1;
			wr_data[r_idx] = res.ent;
			wr_en[res.pos] = 1'b1;
			wr_data[res.pos] = ents[r_idx];
		end
		inject = '0;
		if (state_q == StRun && cnt_q == '0 && !out_v_q) begin
			inject.match = !is_sel_q;
			inject.sel = is_sel_q;
			inject.pos = r_idx;
			if (is_sel_q) begin
				inject.ent = ents[r_idx];
			end else begin
				inject.ent.key = item_q.address_key;
				inject.ent.count = '0;
			end
		end
	end

	assign in_ready = (state_q == StIdle) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			top_q <= sft_pkg::TopCountReset;
			used_q <= '0;
			rows_q <= '0;
			r_q <= '0;
			cnt_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			is_sel_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				top_q <= cfg_wdata;
			end
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (in_valid && in_ready) begin
						cnt_q <= '0;
						r_q <= '0;
						rows_q <= rows_c;
						if (in_data.opcode == sft_pkg::OpRecord) begin
							is_sel_q <= 1'b0;
							state_q <= StRun;
						end else if (rows_c == '0) begin
							out_q <= EmptyRow;
							out_v_q <= 1'b1;
							used_q <= '0;
						end else begin
							is_sel_q <= 1'b1;
							state_q <= StRun;
						end
					end
				end
				StRun: begin
					// wait for the previous row to leave before a new pass
					if (!run_hold) begin
						if (cnt_q == UW'(N - 1)) begin
							state_q <= is_sel_q ? StPick : StRec;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				StRec: begin
					if (!res.found && used_q < UW'(N)) begin
						used_q <= used_q + 1'b1;
					end
					state_q <= StIdle;
				end
				StPick: begin
					out_q <= '{row_valid: 1'b1, rank: r_q[5:0], ranked_key: res.ent.key,
						ranked_reg_low: res.ent.reg_low, ranked_reg_high: res.ent.reg_high,
						sighting_total: res.ent.count, last_row: (r_q + 7'd1 == rows_q)};
					state_q <= StEmit;
				end
				StEmit: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						cnt_q <= '0;
						if (r_q + 7'd1 == rows_q) begin
							used_q <= '0;
							state_q <= StIdle;
						end else begin
							r_q <= r_q + 7'd1;
							state_q <= StRun;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == StIdle) else $error("ready outside idle");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(N)) else $error("table overfilled");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("row changed while stalled");
endmodule
`default_nettype wire
